@@ rtl/core/midi_transpose_and_clock_tempo_top_assert.svh @@
// ----------------------------------------------------------------------------
// midi transpose and clock tempo assertion macros
// concurrent assertion helpers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef MIDI_TRANSPOSE_AND_CLOCK_TEMPO_TOP_ASSERT_SVH
`define MIDI_TRANSPOSE_AND_CLOCK_TEMPO_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MTCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MTCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTCT_ASSERT_IMP(lbl, ante, cons, msg)
`define MTCT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/mtct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtct_pkg
// shared types and constants of the midi transpose and clock tempo block
// ----------------------------------------------------------------------------
package mtct_pkg;

  localparam int CLOCKS_PER_QUARTER = 24;
  localparam int TALLY_W            = 5;

  localparam logic [7:0]  STATUS_CLOCK  = 8'hF8;
  localparam logic [3:0]  KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0]  KIND_NOTE_OFF = 4'h8;

  localparam logic [6:0]  NOTE_MAX    = 7'd127;
  localparam logic [7:0]  TEMPO_MAX   = 8'd240;
  localparam logic [7:0]  TEMPO_RESET = 8'd98;

  localparam logic [14:0] VEL_ROUND = 15'd50;
  localparam logic [12:0] VEL_RECIP = 13'd5243;
  localparam int          VEL_SHIFT = 19;

  localparam logic [6:0]  TEMPO_NUM_MUL = 7'd120;
  localparam int          DIV_STEPS     = 34;
  localparam int          DIV_CNT_W     = 6;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [1:0] REG_TRANSPOSE = 2'd0;
  localparam logic [1:0] REG_VEL_SCALE = 2'd1;
  localparam logic [1:0] REG_SRATE     = 2'd2;

  localparam logic signed [5:0] TRANSPOSE_RESET = 6'sd0;
  localparam logic [7:0]        VEL_SCALE_RESET = 8'd100;
  localparam logic [17:0]       SRATE_RESET     = 18'd48000;

  typedef struct packed {
    logic        is_clock;
    logic [7:0]  status;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [31:0] stamp;
  } mtct_entry_t;

  typedef struct packed {
    logic        start;
    logic [33:0] num;
    logic [32:0] den;
  } mtct_div_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] quot;
  } mtct_div_rsp_t;

endpackage

@@ rtl/core/mtct_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtct_front
// accepts messages, classifies them, transposes notes and scales velocity
// ----------------------------------------------------------------------------
module mtct_front import mtct_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_status,
  input  logic [6:0]         in_data_one,
  input  logic [6:0]         in_data_two,
  input  logic [31:0]        in_stamp,
  input  logic signed [5:0]  transpose,
  input  logic [7:0]         vel_scale,
  output logic               push,
  output mtct_entry_t        push_data,
  input  logic               full
);

  typedef enum logic [1:0] {S_IDLE, S_SCALE, S_PUSH} state_t;

  state_t             state_r, state_nxt;
  mtct_entry_t        ent_r, ent_nxt;
  logic               scale_r, scale_nxt;
  logic [14:0]        prod_r, prod_nxt;

  logic signed [8:0]  note_sum;
  logic [6:0]         note_clamp;
  logic [27:0]        recip_prod;
  logic [8:0]         vel_q;
  logic [6:0]         vel_sat;
  logic               is_note_on;
  logic               is_note_off;

  always_comb begin
    note_sum = $signed({2'b00, in_data_one}) + 9'(transpose);
    if (note_sum < 0) begin
      note_clamp = '0;
    end else if (note_sum > $signed({2'b00, NOTE_MAX})) begin
      note_clamp = NOTE_MAX;
    end else begin
      note_clamp = note_sum[6:0];
    end
    is_note_on  = (in_status[7:4] == KIND_NOTE_ON);
    is_note_off = (in_status[7:4] == KIND_NOTE_OFF);
  end

  assign recip_prod = 28'(prod_r) * 28'(VEL_RECIP);
  assign vel_q      = recip_prod[27:VEL_SHIFT];
  assign vel_sat    = (vel_q > 9'(NOTE_MAX)) ? NOTE_MAX : vel_q[6:0];

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    scale_nxt = scale_r;
    prod_nxt  = prod_r;
    push      = 1'b0;
    push_data = ent_r;
    if (scale_r) begin
      push_data.data_two = vel_sat;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ent_nxt.is_clock = (in_status == STATUS_CLOCK);
          ent_nxt.status   = in_status;
          ent_nxt.data_one = in_data_one;
          ent_nxt.data_two = in_data_two;
          ent_nxt.stamp    = in_stamp;
          scale_nxt        = 1'b0;
          if (is_note_on || is_note_off) begin
            ent_nxt.data_one = note_clamp;
          end
          if (is_note_on) begin
            if (in_data_two == 7'd0) begin
              ent_nxt.status = {KIND_NOTE_OFF, in_status[3:0]};
            end else begin
              scale_nxt = 1'b1;
            end
          end
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        prod_nxt  = 15'(ent_r.data_two) * 15'(vel_scale) + VEL_ROUND;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (!full) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ent_r   <= ent_nxt;
    scale_r <= scale_nxt;
    prod_r  <= prod_nxt;
  end

endmodule

@@ rtl/core/mtct_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtct_fifo
// short queue of classified messages between front and back
// ----------------------------------------------------------------------------
module mtct_fifo import mtct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  mtct_entry_t  push_data,
  output logic         full,
  input  logic         pop,
  output mtct_entry_t  pop_data,
  output logic         empty
);

  mtct_entry_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW:0]    wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW:0]    rd_ptr_r, rd_ptr_nxt;
  logic                head_vld_r, head_vld_nxt;
  mtct_entry_t         head_r;

  logic                mem_empty;
  logic                wr_en;
  logic                rd_en;

  assign mem_empty = (wr_ptr_r == rd_ptr_r);
  assign full      = (wr_ptr_r[FIFO_AW] != rd_ptr_r[FIFO_AW]) &&
                     (wr_ptr_r[FIFO_AW-1:0] == rd_ptr_r[FIFO_AW-1:0]);
  assign wr_en     = push && !full;
  assign rd_en     = !mem_empty && (!head_vld_r || pop);
  assign empty     = !head_vld_r;
  assign pop_data  = head_r;

  always_comb begin
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    head_vld_nxt = head_vld_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt   = rd_ptr_r + 1'b1;
      head_vld_nxt = 1'b1;
    end else if (pop && head_vld_r) begin
      head_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      head_vld_r <= 1'b0;
    end else begin
      wr_ptr_r   <= wr_ptr_nxt;
      rd_ptr_r   <= rd_ptr_nxt;
      head_vld_r <= head_vld_nxt;
    end
    if (wr_en) begin
      mem_r[wr_ptr_r[FIFO_AW-1:0]] <= push_data;
    end
    if (rd_en) begin
      head_r <= mem_r[rd_ptr_r[FIFO_AW-1:0]];
    end
  end

endmodule

@@ rtl/core/mtct_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtct_div
// restoring divider, one quotient bit per cycle, for the tempo update
// ----------------------------------------------------------------------------
module mtct_div import mtct_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  mtct_div_req_t  req,
  output mtct_div_rsp_t  rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [33:0]           dq_r, dq_nxt;
  logic [32:0]           rem_r, rem_nxt;
  logic [32:0]           den_r, den_nxt;

  logic [33:0]           rem_sh;
  logic [34:0]           diff;

  assign rem_sh = {rem_r, dq_r[33]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      dq_nxt   = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[32:0], ~diff[34]};
      rem_nxt = diff[34] ? rem_sh[32:0] : diff[32:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = dq_r;

endmodule

@@ rtl/core/mtct_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtct_back
// tempo tracker on clock messages and output register of the result stream
// ----------------------------------------------------------------------------
`include "midi_transpose_and_clock_tempo_top_assert.svh"

module mtct_back import mtct_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [17:0]   srate,
  input  logic          empty,
  input  mtct_entry_t   pop_data,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,
  output logic          out_tuser
);

  typedef enum logic {S_RUN, S_DIV} state_t;

  state_t               state_r, state_nxt;
  logic                 have_r, have_nxt;
  logic [31:0]          last_r, last_nxt;
  logic [31:0]          sum_r, sum_nxt;
  logic [TALLY_W-1:0]   tally_r, tally_nxt;
  logic [7:0]           tempo_r, tempo_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_msg_r, out_msg_nxt;
  logic [7:0]           out_status_r, out_status_nxt;
  logic [6:0]           out_d1_r, out_d1_nxt;
  logic [6:0]           out_d2_r, out_d2_nxt;
  logic [31:0]          out_time_r, out_time_nxt;
  logic [7:0]           out_tempo_r, out_tempo_nxt;
  logic [24:0]          num_base_r;

  logic [31:0]          interval;
  logic [32:0]          sum_add;
  logic [31:0]          sum_new;
  logic [TALLY_W-1:0]   tally_new;
  mtct_div_req_t        div_req;
  mtct_div_rsp_t        div_rsp;

  mtct_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign interval  = pop_data.stamp - last_r;
  assign sum_add   = {1'b0, sum_r} + {1'b0, interval};
  assign sum_new   = sum_add[32] ? '1 : sum_add[31:0];
  assign tally_new = tally_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    have_nxt       = have_r;
    last_nxt       = last_r;
    sum_nxt        = sum_r;
    tally_nxt      = tally_r;
    tempo_nxt      = tempo_r;
    out_valid_nxt  = out_valid_r;
    out_msg_nxt    = out_msg_r;
    out_status_nxt = out_status_r;
    out_d1_nxt     = out_d1_r;
    out_d2_nxt     = out_d2_r;
    out_time_nxt   = out_time_r;
    out_tempo_nxt  = out_tempo_r;
    pop            = 1'b0;
    div_req.start  = 1'b0;
    div_req.num    = 34'(num_base_r) + 34'(sum_new);
    div_req.den    = {sum_new, 1'b0};
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_RUN: begin
        if (!empty && (!out_valid_r || out_tready)) begin
          pop            = 1'b1;
          out_valid_nxt  = 1'b1;
          out_msg_nxt    = !pop_data.is_clock;
          out_status_nxt = pop_data.status;
          out_d1_nxt     = pop_data.data_one;
          out_d2_nxt     = pop_data.data_two;
          out_time_nxt   = pop_data.stamp;
          if (pop_data.is_clock) begin
            out_status_nxt = '0;
            out_d1_nxt     = '0;
            out_d2_nxt     = '0;
            out_time_nxt   = '0;
            have_nxt       = 1'b1;
            last_nxt       = pop_data.stamp;
            if (have_r) begin
              sum_nxt   = sum_new;
              tally_nxt = tally_new;
              if (tally_new >= TALLY_W'(CLOCKS_PER_QUARTER)) begin
                sum_nxt   = '0;
                tally_nxt = '0;
                if (sum_new == '0) begin
                  tempo_nxt = TEMPO_MAX;
                end else begin
                  div_req.start = 1'b1;
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_DIV;
                end
              end
            end
          end
          out_tempo_nxt = tempo_nxt;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > 34'(TEMPO_MAX)) begin
            tempo_nxt = TEMPO_MAX;
          end else begin
            tempo_nxt = div_rsp.quot[7:0];
          end
          out_tempo_nxt = tempo_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      have_r      <= 1'b0;
      last_r      <= '0;
      sum_r       <= '0;
      tally_r     <= '0;
      tempo_r     <= TEMPO_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      last_r      <= last_nxt;
      sum_r       <= sum_nxt;
      tally_r     <= tally_nxt;
      tempo_r     <= tempo_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_msg_r    <= out_msg_nxt;
    out_status_r <= out_status_nxt;
    out_d1_r     <= out_d1_nxt;
    out_d2_r     <= out_d2_nxt;
    out_time_r   <= out_time_nxt;
    out_tempo_r  <= out_tempo_nxt;
    num_base_r   <= 25'(srate) * 25'(TEMPO_NUM_MUL);
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_msg_r;
  assign out_tdata  = {2'b00, out_tempo_r, out_time_r, out_d2_r, out_d1_r, out_status_r};

  `MTCT_ASSERT_IMP(a_done_in_div, div_rsp.done, state_r == S_DIV, "divider done outside wait")
  `MTCT_ASSERT_IMP(a_no_out_in_div, state_r == S_DIV, !out_valid_r, "result shown while dividing")
  `MTCT_ASSERT_IMP(a_tally_range, 1'b1, tally_r < TALLY_W'(CLOCKS_PER_QUARTER), "tally overrun")
  `MTCT_ASSERT_NXT(a_start_waits, div_req.start, state_r == S_DIV, "start without wait state")

endmodule

@@ rtl/core/midi_transpose_and_clock_tempo_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_transpose_and_clock_tempo_top
// midi note transpose, velocity scaling and midi clock tempo tracking
// ----------------------------------------------------------------------------
// Input stream: one midi message per transaction. Output stream: exactly one
// result per input transaction, in order; out_tuser low marks a swallowed
// clock message, whose data fields read zero but still carry the tempo.
// The front stage takes a message and pushes it before it takes another,
// queueing it in a 4-entry fifo with a registered read port; the back stage
// drains one entry per cycle into the output register while the output is
// free and no divide is running. A plain message passes through the front
// registers, the fifo memory and its head register to the output register.
// A clock message that completes a quarter note starts a restoring divide
// for the new tempo; that result appears once the divide is done, and until
// then the back stage holds and results behind it wait on the divider.
// Reset clears the tempo tracker (tempo 98) and the registers to their
// defaults: transpose 0, velocity scale 100, sample rate 48000.
// When out_tready is low the result holds; the fifo fills and then in_tready
// drops. The user must write the registers over the apb port only while
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module midi_transpose_and_clock_tempo_top import mtct_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,    // status_byte, data_one, data_two, sample_time
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,   // out_status, out_data_one, out_data_two, out_time,
                                    // tempo_bpm
  output logic         out_tuser,   // message_valid
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic signed [5:0]  transpose_r;
  logic [7:0]         vel_scale_r;
  logic [17:0]        srate_r;
  logic               cfg_wr;

  mtct_entry_t        push_data;
  mtct_entry_t        pop_data;
  logic               push;
  logic               pop;
  logic               full;
  logic               empty;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= TRANSPOSE_RESET;
      vel_scale_r <= VEL_SCALE_RESET;
      srate_r     <= SRATE_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_TRANSPOSE: transpose_r <= $signed(cfg_pwdata[5:0]);
        REG_VEL_SCALE: vel_scale_r <= cfg_pwdata[7:0];
        REG_SRATE:     srate_r     <= cfg_pwdata[17:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TRANSPOSE: cfg_prdata = {26'd0, transpose_r};
      REG_VEL_SCALE: cfg_prdata = {24'd0, vel_scale_r};
      REG_SRATE:     cfg_prdata = {14'd0, srate_r};
      default:       cfg_prdata = '0;
    endcase
  end

  mtct_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_status   (in_tdata[7:0]),
    .in_data_one (in_tdata[14:8]),
    .in_data_two (in_tdata[21:15]),
    .in_stamp    (in_tdata[53:22]),
    .transpose   (transpose_r),
    .vel_scale   (vel_scale_r),
    .push        (push),
    .push_data   (push_data),
    .full        (full)
  );

  mtct_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  mtct_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .srate      (srate_r),
    .empty      (empty),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ tb/midi_transpose_and_clock_tempo_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_transpose_and_clock_tempo_top_tb
// self-checking bench for note transpose, velocity scaling and clock tempo
// ----------------------------------------------------------------------------
// Drives midi messages into the input stream in random bursts, predicts every
// result with a behavioral tempo tracker and note shaper, and compares each
// output transaction field by field in order. Directed notes cover the data
// extremes and clamping. Random phases change the registers between runs of
// clock sequences with steady, zero, tiny, huge and wrapping intervals. The
// output side stalls on its own pattern and once for a long stretch.
// ----------------------------------------------------------------------------
module midi_transpose_and_clock_tempo_top_tb;
  import mtct_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          IDLE_SETTLE    = 48;
  localparam int          PHASE_ITEMS    = 90;
  localparam int          RANDOM_PHASES  = 12;
  localparam int unsigned VEL_UNITY      = 100;
  localparam int unsigned VEL_HALF       = 50;
  localparam longint unsigned SECONDS_PER_MINUTE = 60;

  typedef enum int {GAP_STEADY, GAP_ZERO, GAP_TINY, GAP_HUGE, GAP_WILD} clock_gap_e;
  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN} sink_mode_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  status;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [31:0] stamp;
    logic [7:0]  tempo;
  } midi_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // status_byte, data_one, data_two, sample_time
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // out_status, out_data_one, out_data_two, out_time, tempo_bpm
  logic        out_tuser;  // message_valid
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  midi_transpose_and_clock_tempo_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor copy of registers and tempo tracker
  logic signed [5:0] shift_semitones;
  logic [7:0]        velocity_gain;
  logic [17:0]       rate_hz;
  logic              seen_clock;
  logic [31:0]       prev_clock_stamp;
  logic [31:0]       interval_total;
  logic [4:0]        clock_count;
  logic [7:0]        tempo_now;

  midi_result_t pending_results[$];
  int           error_count;
  int           idle_cycles;
  int           burst_left;
  bit           sender_gaps;
  bit           hold_request;
  clock_gap_e   gap_mode;
  logic [31:0]  clock_stamp;
  logic [31:0]  steady_interval;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic logic [6:0] shifted_note(input logic [6:0] note_in);
    int note;
    note = int'(note_in) + int'(shift_semitones);
    if (note < 0) note = 0;
    if (note > int'(NOTE_MAX)) note = int'(NOTE_MAX);
    return 7'(note);
  endfunction

  function automatic void advance_tempo(input logic [31:0] stamp);
    logic [32:0]     total;
    longint unsigned quotient;
    if (seen_clock) begin
      total = {1'b0, interval_total} + {1'b0, stamp - prev_clock_stamp};
      interval_total = total[32] ? 32'hFFFF_FFFF : total[31:0];
      clock_count = clock_count + 5'd1;
      if (clock_count >= CLOCKS_PER_QUARTER) begin
        if (interval_total == 0) begin
          tempo_now = TEMPO_MAX;
        end else begin
          quotient = (2 * SECONDS_PER_MINUTE * longint'(rate_hz) + longint'(interval_total))
                     / (2 * longint'(interval_total));
          tempo_now = (quotient > TEMPO_MAX) ? TEMPO_MAX : 8'(quotient);
        end
        interval_total = '0;
        clock_count = '0;
      end
    end
    seen_clock = 1'b1;
    prev_clock_stamp = stamp;
  endfunction

  function automatic midi_result_t shape_message(input logic [7:0] status,
      input logic [6:0] note, input logic [6:0] velocity, input logic [31:0] stamp);
    midi_result_t res;
    int unsigned  scaled;
    res = '0;
    if (status == STATUS_CLOCK) begin
      advance_tempo(stamp);
    end else begin
      res.valid = 1'b1;
      res.status = status;
      res.note = note;
      res.velocity = velocity;
      res.stamp = stamp;
      if (status[7:4] == KIND_NOTE_ON) begin
        res.note = shifted_note(note);
        if (velocity == 0) begin
          res.status = {KIND_NOTE_OFF, status[3:0]};
        end else begin
          scaled = (int'(velocity) * int'(velocity_gain) + VEL_HALF) / VEL_UNITY;
          res.velocity = (scaled > NOTE_MAX) ? NOTE_MAX : 7'(scaled);
        end
      end else if (status[7:4] == KIND_NOTE_OFF) begin
        res.note = shifted_note(note);
      end
    end
    res.tempo = tempo_now;
    return res;
  endfunction

  task automatic send_message(input logic [7:0] status, input logic [6:0] note,
      input logic [6:0] velocity, input logic [31:0] stamp);
    int gap;
    gap = 0;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 12) : 0;
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, stamp, velocity, note, status};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(shape_message(status, note, velocity, stamp));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (index)
      REG_TRANSPOSE: shift_semitones = value[5:0];
      REG_VEL_SCALE: velocity_gain = value[7:0];
      REG_SRATE:     rate_hz = value[17:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input logic [5:0] semis, input logic [7:0] gain,
      input logic [17:0] rate);
    wait_idle();
    write_register(REG_TRANSPOSE, {26'd0, semis});
    write_register(REG_VEL_SCALE, {24'd0, gain});
    write_register(REG_SRATE, {14'd0, rate});
  endtask

  function automatic logic [31:0] next_clock_gap();
    case (gap_mode)
      GAP_STEADY: return steady_interval + $urandom_range(0, 15);
      GAP_ZERO:   return '0;
      GAP_TINY:   return $urandom_range(0, 40);
      GAP_HUGE:   return $urandom_range(32'h2000_0000, 32'hFFFF_FFFF);
      default:    return $urandom;
    endcase
  endfunction

  task automatic send_random_item();
    int          pick;
    logic [7:0]  status;
    logic [6:0]  velocity;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      clock_stamp = clock_stamp + next_clock_gap();
      send_message(STATUS_CLOCK, 7'($urandom), 7'($urandom), clock_stamp);
    end else if (pick < 88) begin
      status = {($urandom_range(0, 1) ? KIND_NOTE_ON : KIND_NOTE_OFF), 4'($urandom)};
      velocity = ($urandom_range(0, 5) == 0) ? 7'd0 : 7'($urandom);
      send_message(status, 7'($urandom), velocity, $urandom);
    end else if (pick < 97) begin
      send_message(8'($urandom), 7'($urandom), 7'($urandom), $urandom);
    end else begin
      // stray clock with an unrelated timestamp
      send_message(STATUS_CLOCK, 7'($urandom), 7'($urandom), $urandom);
    end
  endtask

  task automatic test_pass_through();
    send_message(8'h90, 7'd60, 7'd100, 32'd0);
    send_message(8'h9F, 7'd0, 7'd127, 32'hFFFF_FFFF);
    send_message(8'h93, 7'd127, 7'd0, 32'h8000_0000);
    send_message(8'h80, 7'd127, 7'd127, 32'h7FFF_FFFF);
    send_message(8'h8A, 7'd0, 7'd0, 32'h5555_5555);
    send_message(8'hB0, 7'd127, 7'd127, 32'hAAAA_AAAA);
    send_message(8'hE5, 7'd85, 7'd42, 32'd1);
    send_message(8'hF0, 7'd1, 7'd2, 32'd3);
    send_message(8'hFF, 7'd127, 7'd0, 32'd4);
    send_message(8'h00, 7'd0, 7'd127, 32'd5);
    send_message(8'h7F, 7'd64, 7'd64, 32'd6);
    send_message(STATUS_CLOCK, 7'd0, 7'd0, 32'h0000_1234);
  endtask

  task automatic test_note_clamping();
    apply_setting(6'd31, 8'd255, 18'd48000);
    send_message(8'h90, 7'd127, 7'd127, 32'd10);
    send_message(8'h90, 7'd100, 7'd1, 32'd11);
    send_message(8'h80, 7'd96, 7'd5, 32'd12);
    apply_setting(6'h20, 8'd0, 18'd48000);
    send_message(8'h91, 7'd0, 7'd127, 32'd13);
    send_message(8'h81, 7'd31, 7'd9, 32'd14);
    send_message(8'h91, 7'd32, 7'd0, 32'd15);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    sender_gaps = 1'b0;
    repeat (60) send_random_item();
    sender_gaps = 1'b1;
  endtask

  task automatic test_tempo_phases();
    logic [5:0]      semis;
    logic [7:0]      gain;
    logic [17:0]     rate;
    longint unsigned bpm;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      semis = 6'($urandom);
      gain = 8'($urandom_range(0, 255));
      rate = 18'($urandom_range(0, 262143));
      gap_mode = clock_gap_e'($urandom_range(GAP_STEADY, GAP_WILD));
      clock_stamp = $urandom;
      case (p)
        0: begin semis = 6'd0;  gain = 8'd100; rate = 18'd48000;  gap_mode = GAP_STEADY; end
        1: begin semis = 6'h28; gain = 8'd200; rate = 18'd192000; gap_mode = GAP_STEADY; end
        2: begin semis = 6'd24; gain = 8'd0;   rate = 18'd8000;   gap_mode = GAP_TINY;   end
        3: begin semis = 6'h20; gain = 8'd255; rate = 18'd0;      gap_mode = GAP_STEADY; end
        4: begin
          semis = 6'd31; gain = 8'd1; rate = 18'h3FFFF; gap_mode = GAP_STEADY;
          clock_stamp = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        end
        5: gap_mode = GAP_ZERO;
        6: gap_mode = GAP_HUGE;
        default: ;
      endcase
      bpm = $urandom_range(20, 300);
      steady_interval = (rate == 0) ? $urandom_range(1, 5000)
                      : 32'((SECONDS_PER_MINUTE * rate) / (bpm * CLOCKS_PER_QUARTER));
      apply_setting(semis, gain, rate);
      repeat (PHASE_ITEMS) send_random_item();
    end
  endtask

  // output side stall pattern
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         phase;
    out_tready = 1'b1;
    mode = SINK_ALWAYS;
    mode_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(SINK_ALWAYS, SINK_PATTERN));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      phase++;
      case (mode)
        SINK_ALWAYS: out_tready <= 1'b1;
        SINK_RANDOM: out_tready <= ($urandom_range(0, 99) < 60);
        default:     out_tready <= ((phase % 7) < 4);
      endcase
    end
  end

  task automatic check_field(input string name, input longint unsigned want,
      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    midi_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("message_valid", want.valid, out_tuser);
        check_field("out_status", want.status, out_tdata[7:0]);
        check_field("out_data_one", want.note, out_tdata[14:8]);
        check_field("out_data_two", want.velocity, out_tdata[21:15]);
        check_field("out_time", want.stamp, out_tdata[53:22]);
        check_field("tempo_bpm", want.tempo, out_tdata[61:54]);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    error_count = 0;
    idle_cycles = 0;
    burst_left  = 0;
    sender_gaps = 1'b1;
    hold_request = 1'b0;
    gap_mode    = GAP_STEADY;
    clock_stamp = '0;
    steady_interval = 32'd1000;
    shift_semitones  = TRANSPOSE_RESET;
    velocity_gain    = VEL_SCALE_RESET;
    rate_hz          = SRATE_RESET;
    seen_clock       = 1'b0;
    prev_clock_stamp = '0;
    interval_total   = '0;
    clock_count      = '0;
    tempo_now        = TEMPO_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_pass_through();
    test_note_clamping();
    test_backpressure();
    test_tempo_phases();
    wait_idle();

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
